>>> rtl/core/telnet_nvt_stream_decoder_unit_assert.svh
// Assertion macros shared by the telnet stream decoder modules.
`ifndef TELNET_NVT_STREAM_DECODER_UNIT_ASSERT_SVH
`define TELNET_NVT_STREAM_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked check, masked while reset is asserted.
`define TND_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tnd assertion failed");
// Clocked check that also holds through reset.
`define TND_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tnd reset assertion failed");
`else
`define TND_ASSERT(lbl, clk, rst_n, prop)
`define TND_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> rtl/core/tnd_pkg.sv
// Shared constants and types for the telnet stream decoder.
package tnd_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_SE   = 8'hf0;
    localparam logic [7:0] TN_SB   = 8'hfa;
    localparam logic [7:0] TN_WONT = 8'hfc;
    localparam logic [7:0] TN_DO   = 8'hfd;
    localparam logic [7:0] TN_IAC  = 8'hff;

    // NVT control characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;

    // Default depth of the request queue between parser and emitter
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // Parser modes
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_IAC    = 6'b000010,
        MODE_DO     = 6'b000100,
        MODE_SKIP   = 6'b001000,
        MODE_SB     = 6'b010000,
        MODE_SB_IAC = 6'b100000
    } t_mode;

    // One queued request: a data byte, or an option refusal for value
    typedef struct packed {
        logic       reply;
        logic [7:0] value;
    } t_op;

endpackage

>>> rtl/core/tnd_front.sv
// Front end: parses input bytes and queues emit requests.
`include "telnet_nvt_stream_decoder_unit_assert.svh"
module tnd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_buffer_start,
    input  logic          i_q_full,
    output logic          o_push,
    output tnd_pkg::t_op  o_op
);
    import tnd_pkg::*;

    t_mode r_mode, n_mode, w_mode;
    logic  r_cr, n_cr, w_cr;
    logic  w_accept;
    logic  w_emit;
    t_op   w_op;

    // Parse one byte against the current (or freshly cleared) state
    always_comb begin
        w_accept = i_valid && !i_q_full;
        w_mode   = i_buffer_start ? MODE_NORMAL : r_mode;
        w_cr     = i_buffer_start ? 1'b0 : r_cr;
        n_mode   = w_mode;
        n_cr     = w_cr;
        w_emit   = 1'b0;
        w_op.reply = 1'b0;
        w_op.value = i_in_byte;
        case (w_mode)
            MODE_IAC: begin
                if (i_in_byte == TN_IAC) begin
                    w_emit = 1'b1;
                    n_mode = MODE_NORMAL;
                end else if (i_in_byte == TN_SB) begin
                    n_mode = MODE_SB;
                end else if (i_in_byte == TN_DO) begin
                    n_mode = MODE_DO;
                end else begin
                    n_mode = MODE_SKIP;
                end
            end
            MODE_DO: begin
                // IAC DO IAC is an escaped 0xFF, anything else is refused
                w_emit     = 1'b1;
                w_op.reply = (i_in_byte != TN_IAC);
                n_mode     = MODE_NORMAL;
            end
            MODE_SKIP: begin
                n_mode = MODE_NORMAL;
            end
            MODE_SB: begin
                if (i_in_byte == TN_IAC) begin
                    n_mode = MODE_SB_IAC;
                end
            end
            MODE_SB_IAC: begin
                n_mode = (i_in_byte == TN_SE) ? MODE_NORMAL : MODE_SB;
            end
            default: begin
                // normal data, with CR NUL / CR LF folding
                n_mode = MODE_NORMAL;
                n_cr   = 1'b0;
                if (w_cr && (i_in_byte == CHAR_NUL)) begin
                    w_emit     = 1'b1;
                    w_op.value = CHAR_CR;
                end else if (w_cr && (i_in_byte == CHAR_LF)) begin
                    w_emit = 1'b1;
                end else if (i_in_byte == TN_IAC) begin
                    n_mode = MODE_IAC;
                end else if (i_in_byte == CHAR_CR) begin
                    n_cr = 1'b1;
                end else begin
                    w_emit = 1'b1;
                end
            end
        endcase
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cr   <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_cr   <= n_cr;
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = w_accept && w_emit;
    assign o_op    = w_op;

    // A CR mark only lives in normal data mode
    `TND_ASSERT(a_cr_in_normal, i_clk, i_rst_n, r_cr |-> (r_mode == MODE_NORMAL))
    // A refused option always queues a reply request
    `TND_ASSERT(a_do_refuse, i_clk, i_rst_n, (w_accept && !i_buffer_start && (r_mode == MODE_DO) && (i_in_byte != TN_IAC)) |-> (o_push && o_op.reply))
    // Subnegotiation persists until IAC is seen
    `TND_ASSERT(a_sb_hold, i_clk, i_rst_n, (w_accept && !i_buffer_start && (r_mode == MODE_SB) && (i_in_byte != TN_IAC)) |=> (r_mode == MODE_SB))

endmodule

>>> rtl/core/tnd_queue.sv
// Request queue decoupling the parser from the output emitter.
module tnd_queue #(
    parameter int QueueDepth = tnd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tnd_pkg::t_op  i_op,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tnd_pkg::t_op  o_head
);
    import tnd_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_op             r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

>>> rtl/core/tnd_back.sv
// Back end: expands queued requests into registered result bytes.
`include "telnet_nvt_stream_decoder_unit_assert.svh"
module tnd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tnd_pkg::t_op  i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_out_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);
    import tnd_pkg::*;

    // Beat sequencer for the three-byte refusal
    typedef enum logic [2:0] {
        BEAT_IAC = 3'b001,
        BEAT_CMD = 3'b010,
        BEAT_OPT = 3'b100
    } t_beat;

    t_beat      r_beat, n_beat;
    logic       r_valid, n_valid;
    logic       r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       w_load;
    logic       w_pop;

    // Load the output register whenever it is empty or being taken
    always_comb begin
        w_load  = !r_valid || !i_stall;
        w_pop   = 1'b0;
        n_beat  = r_beat;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_byte  = r_byte;
        n_last  = r_last;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.reply) begin
                    n_kind = 1'b1;
                    case (r_beat)
                        BEAT_IAC: begin
                            n_byte = TN_IAC;
                            n_last = 1'b0;
                            n_beat = BEAT_CMD;
                        end
                        BEAT_CMD: begin
                            n_byte = TN_WONT;
                            n_last = 1'b0;
                            n_beat = BEAT_OPT;
                        end
                        default: begin
                            n_byte = i_head.value;
                            n_last = 1'b1;
                            n_beat = BEAT_IAC;
                            w_pop  = 1'b1;
                        end
                    endcase
                end else begin
                    n_kind = 1'b0;
                    n_byte = i_head.value;
                    n_last = 1'b1;
                    w_pop  = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_IAC;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_pop      = w_pop;
    assign o_valid    = r_valid;
    assign o_out_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

    // Mid-refusal beats always have a result on the port
    `TND_ASSERT(a_beat_valid, i_clk, i_rst_n, (r_beat != BEAT_IAC) |-> r_valid)
    // Only refusals produce results that are not the last one
    `TND_ASSERT(a_multi_is_reply, i_clk, i_rst_n, (r_valid && !r_last) |-> r_kind)
    // Reset empties the output and restarts the sequencer
    `TND_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> (!r_valid && (r_beat == BEAT_IAC)))

endmodule

>>> rtl/core/telnet_nvt_stream_decoder_unit.sv
// Top level of the telnet NVT stream decoder that refuses every IAC DO option.
//
// Input channel (i_valid / o_stall): one raw telnet byte per request, with
// i_buffer_start set on the first byte of a buffer to clear the parser.
// Output channel (o_valid / i_stall): one result byte per request, with its
// kind (0 data, 1 negotiation reply) and o_out_last on the final result
// caused by an input byte. Bytes that cause no result produce nothing.
// An accepted byte's request is written into the request queue, then loaded
// into the output register. Throughput: one input byte per cycle while the
// output is not stalled and each byte gives at most one result; an IAC DO x
// refusal gives three output bytes. A request queue of QueueDepth entries
// sits between the parser and the emitter, so the parser keeps accepting
// bytes while the output is stalled until the queue fills; o_stall is then
// raised. A stalled result holds its value until taken.
// Reset (synchronous, active low) returns the parser to normal data mode,
// clears the CR mark, empties the queue and drops any pending result.
module telnet_nvt_stream_decoder_unit #(
    parameter int QueueDepth = tnd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_buffer_start,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import tnd_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_op  w_op;
    t_op  w_head;

    // Parser
    tnd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_buffer_start (i_buffer_start),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_op           (w_op)
    );

    // Request queue
    tnd_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Emitter
    tnd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_kind (o_out_kind),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule
